// ----- hw/rtl/rar_pkg.sv -----
// Package for the rational adder with GCD reduction.
// Holds field widths, the controller state type and the command/status structs.
// No dependencies.
package rar_pkg;

    localparam int FIELD_BITS        = 32;
    localparam int WORD_BITS_DEFAULT = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CHECK,
        ST_GCD,
        ST_DIV_NUM,
        ST_STORE_NUM,
        ST_DIV_DEN,
        ST_STORE_DEN,
        ST_OUT
    } rar_state_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic sum_step;
        logic gcd_init;
        logic gcd_step;
        logic div_init_num;
        logic div_init_den;
        logic div_step;
        logic store_num;
        logic store_den;
        logic out_load;
    } rar_cmd_t;

    typedef struct packed {
        logic zero_raw;
        logic gcd_done;
    } rar_status_t;

endpackage

// ----- hw/rtl/rar_operand_if.sv -----
// Input channel of the rational adder: two fractions per item.
// Depends on rar_pkg.
interface rar_operand_if;
    import rar_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] first_numerator;
    logic [FIELD_BITS-1:0] first_denominator;
    logic [FIELD_BITS-1:0] second_numerator;
    logic [FIELD_BITS-1:0] second_denominator;

    modport source (
        output valid, first_numerator, first_denominator,
               second_numerator, second_denominator,
        input  ready
    );

    modport sink (
        input  valid, first_numerator, first_denominator,
               second_numerator, second_denominator,
        output ready
    );
endinterface

// ----- hw/rtl/rar_result_if.sv -----
// Output channel of the rational adder: reduced sum and overflow flag per item.
// Depends on rar_pkg.
interface rar_result_if;
    import rar_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] sum_numerator;
    logic [FIELD_BITS-1:0] sum_denominator;
    logic                  overflow;

    modport source (
        output valid, sum_numerator, sum_denominator, overflow,
        input  ready
    );

    modport sink (
        input  valid, sum_numerator, sum_denominator, overflow,
        output ready
    );
endinterface

// ----- hw/rtl/rational_add_reduce.sv -----
// Top level of the rational adder: a/b + c/d reduced by the GCD.
// Depends on rar_pkg, rar_operand_if, rar_result_if, rar_ctrl, rar_datapath.
//
//   channel    dir  modport  payload
//   operands   in   sink     first/second numerator and denominator, 32 bits each
//   result     out  source   sum_numerator, sum_denominator (32), overflow (1)
//
// One item at a time; an item is accepted, multiplied by shift-add, summed and
// checked, reduced by binary GCD (one shift or subtract per cycle) and divided by
// two restoring divisions before the output load.
// A zero raw value skips the GCD and divisions.
// The result sits in an output register; the next item is taken while it waits.
// rst_n clears the controller and the output valid flag asynchronously.
module rational_add_reduce #(
    parameter int WORD_BITS = rar_pkg::WORD_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    rar_operand_if.sink   operands,
    rar_result_if.source  result
);
    import rar_pkg::*;

    rar_cmd_t    cmd;
    rar_status_t status;

    rar_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operands.valid),
        .operand_ready (operands.ready),
        .result_valid  (result.valid),
        .result_ready  (result.ready),
        .status        (status),
        .cmd           (cmd)
    );

    rar_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk                (clk),
        .cmd                (cmd),
        .first_numerator    (operands.first_numerator),
        .first_denominator  (operands.first_denominator),
        .second_numerator   (operands.second_numerator),
        .second_denominator (operands.second_denominator),
        .status             (status),
        .sum_numerator      (result.sum_numerator),
        .sum_denominator    (result.sum_denominator),
        .overflow           (result.overflow)
    );

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_step, cmd.sum_step, cmd.gcd_step, cmd.div_step,
                  cmd.out_load}))
        else $error("datapath commands overlap");

    a_gcd_step_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gcd_step |-> !status.gcd_done)
        else $error("GCD stepped after convergence");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.out_load))
        else $error("result valid raised without an output load");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (operands.valid && operands.ready) |-> (cmd.load && !cmd.out_load))
        else $error("accepted item not loaded");

endmodule

// ----- hw/rtl/rar_datapath.sv -----
// Datapath: shift-add multipliers, cross sum, binary GCD, restoring divider
// and the output payload register. Driven by rar_ctrl commands; uses rar_pkg.
module rar_datapath #(
    parameter int WORD_BITS = rar_pkg::WORD_BITS_DEFAULT
) (
    input  logic                           clk,
    input  rar_pkg::rar_cmd_t              cmd,
    input  logic [rar_pkg::FIELD_BITS-1:0] first_numerator,
    input  logic [rar_pkg::FIELD_BITS-1:0] first_denominator,
    input  logic [rar_pkg::FIELD_BITS-1:0] second_numerator,
    input  logic [rar_pkg::FIELD_BITS-1:0] second_denominator,
    output rar_pkg::rar_status_t           status,
    output logic [rar_pkg::FIELD_BITS-1:0] sum_numerator,
    output logic [rar_pkg::FIELD_BITS-1:0] sum_denominator,
    output logic                           overflow
);
    import rar_pkg::*;

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int K_BITS    = $clog2(WORD_BITS);

    logic [PROD_BITS-1:0] a_sh_reg, a_sh_next;
    logic [PROD_BITS-1:0] b_sh_reg, b_sh_next;
    logic [WORD_BITS-1:0] c_sh_reg, c_sh_next;
    logic [WORD_BITS-1:0] d_sh_reg, d_sh_next;
    logic [PROD_BITS-1:0] den_acc_reg, den_acc_next;
    logic [PROD_BITS-1:0] t1_acc_reg, t1_acc_next;
    logic [PROD_BITS-1:0] t2_acc_reg, t2_acc_next;
    logic [WORD_BITS-1:0] num_reg, num_next;
    logic [WORD_BITS-1:0] den_reg, den_next;
    logic                 ovf_reg, ovf_next;
    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] y_reg, y_next;
    logic [K_BITS-1:0]    k_reg, k_next;
    logic [WORD_BITS-1:0] divisor_reg, divisor_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [FIELD_BITS-1:0] out_num_reg, out_num_next;
    logic [FIELD_BITS-1:0] out_den_reg, out_den_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic [WORD_BITS:0] sum_w;
    logic               prod_hi;
    logic [WORD_BITS:0] trial;
    logic [WORD_BITS:0] diff;
    logic               fits;

    assign sum_w   = {1'b0, t1_acc_reg[WORD_BITS-1:0]} + {1'b0, t2_acc_reg[WORD_BITS-1:0]};
    assign prod_hi = (|den_acc_reg[PROD_BITS-1:WORD_BITS])
                   | (|t1_acc_reg[PROD_BITS-1:WORD_BITS])
                   | (|t2_acc_reg[PROD_BITS-1:WORD_BITS]);
    assign trial   = {rem_reg, quo_reg[WORD_BITS-1]};
    assign diff    = trial - {1'b0, divisor_reg};
    assign fits    = ~diff[WORD_BITS];

    always_comb
    begin
        a_sh_next    = a_sh_reg;
        b_sh_next    = b_sh_reg;
        c_sh_next    = c_sh_reg;
        d_sh_next    = d_sh_reg;
        den_acc_next = den_acc_reg;
        t1_acc_next  = t1_acc_reg;
        t2_acc_next  = t2_acc_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        ovf_next     = ovf_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        k_next       = k_reg;
        divisor_next = divisor_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        out_num_next = out_num_reg;
        out_den_next = out_den_reg;
        out_ovf_next = out_ovf_reg;

        if (cmd.load)
        begin
            a_sh_next    = PROD_BITS'(WORD_BITS'(first_numerator));
            b_sh_next    = PROD_BITS'(WORD_BITS'(first_denominator));
            c_sh_next    = WORD_BITS'(second_numerator);
            d_sh_next    = WORD_BITS'(second_denominator);
            den_acc_next = '0;
            t1_acc_next  = '0;
            t2_acc_next  = '0;
        end

        if (cmd.mul_step)
        begin
            a_sh_next = a_sh_reg << 1;
            b_sh_next = b_sh_reg << 1;
            c_sh_next = c_sh_reg >> 1;
            d_sh_next = d_sh_reg >> 1;
            if (d_sh_reg[0])
            begin
                den_acc_next = den_acc_reg + b_sh_reg;
                t1_acc_next  = t1_acc_reg + a_sh_reg;
            end
            if (c_sh_reg[0])
            begin
                t2_acc_next = t2_acc_reg + b_sh_reg;
            end
        end

        if (cmd.sum_step)
        begin
            num_next = sum_w[WORD_BITS-1:0];
            den_next = den_acc_reg[WORD_BITS-1:0];
            ovf_next = prod_hi | sum_w[WORD_BITS];
        end

        if (cmd.gcd_init)
        begin
            x_next = num_reg;
            y_next = den_reg;
            k_next = '0;
        end

        if (cmd.gcd_step)
        begin
            priority if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg > y_reg)
            begin
                x_next = x_reg - y_reg;
            end
            else
            begin
                y_next = y_reg - x_reg;
            end
        end

        if (cmd.div_init_num || cmd.div_init_den)
        begin
            rem_next = '0;
            quo_next = cmd.div_init_den ? den_reg : num_reg;
        end
        if (cmd.div_init_num)
        begin
            divisor_next = x_reg << k_reg;
        end

        if (cmd.div_step)
        begin
            rem_next = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
            quo_next = {quo_reg[WORD_BITS-2:0], fits};
        end

        if (cmd.store_num)
        begin
            num_next = quo_reg;
        end
        if (cmd.store_den)
        begin
            den_next = quo_reg;
        end

        if (cmd.out_load)
        begin
            out_num_next = FIELD_BITS'(num_reg);
            out_den_next = FIELD_BITS'(den_reg);
            out_ovf_next = ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sh_reg    <= a_sh_next;
        b_sh_reg    <= b_sh_next;
        c_sh_reg    <= c_sh_next;
        d_sh_reg    <= d_sh_next;
        den_acc_reg <= den_acc_next;
        t1_acc_reg  <= t1_acc_next;
        t2_acc_reg  <= t2_acc_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        ovf_reg     <= ovf_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        k_reg       <= k_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign status.zero_raw = (num_reg == '0) || (den_reg == '0);
    assign status.gcd_done = (x_reg == y_reg);

    assign sum_numerator   = out_num_reg;
    assign sum_denominator = out_den_reg;
    assign overflow        = out_ovf_reg;

endmodule

// ----- hw/rtl/rar_ctrl.sv -----
// Controller: sequences multiply, sum, GCD and the two divisions, and owns
// both handshakes. Uses rar_pkg; drives rar_datapath through rar_cmd_t.
module rar_ctrl #(
    parameter int WORD_BITS = rar_pkg::WORD_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 operand_valid,
    output logic                 operand_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  rar_pkg::rar_status_t status,
    output rar_pkg::rar_cmd_t    cmd
);
    import rar_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    rar_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;
        operand_ready  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                operand_ready = 1'b1;
                if (operand_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.zero_raw)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next   = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.div_init_num = 1'b1;
                    cnt_next         = '0;
                    state_next       = ST_DIV_NUM;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV_NUM:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_STORE_NUM;
                end
            end
            ST_STORE_NUM:
            begin
                cmd.store_num    = 1'b1;
                cmd.div_init_den = 1'b1;
                cnt_next         = '0;
                state_next       = ST_DIV_DEN;
            end
            ST_DIV_DEN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_STORE_DEN;
                end
            end
            ST_STORE_DEN:
            begin
                cmd.store_den = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

// ----- tb/sv/rational_add_reduce_tb.sv -----
// Self-checking testbench for rational_add_reduce: a/b + c/d reduced by the GCD.
// Directed table then random items on valid/ready, checked against known rows or a predictor.
// Depends on rar_pkg, rar_operand_if, rar_result_if and the rational_add_reduce RTL.
`timescale 1ns / 1ps

module rational_add_reduce_tb;
    import rar_pkg::*;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int DRAIN_CYCLES  = 400;
    localparam int IDLE_PERCENT  = 27;

    typedef struct packed {
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] b;
        logic [FIELD_BITS-1:0] c;
        logic [FIELD_BITS-1:0] d;
    } fractions_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] num;
        logic [FIELD_BITS-1:0] den;
        logic                  ovf;
    } reduced_sum_t;

    typedef struct packed {
        fractions_t   op;
        logic         known;
        reduced_sum_t res;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic steady = 1'b0;
    int   mismatches = 0;

    reduced_sum_t pending_sums[$];
    table_row_t   directed_rows[$];

    rar_operand_if operands();
    rar_result_if  result();

    rational_add_reduce dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .result   (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic reduced_sum_t predict_sum(input fractions_t op);
        logic [63:0]           den_full;
        logic [63:0]           cross_ad;
        logic [63:0]           cross_bc;
        logic [FIELD_BITS:0]   num_full;
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        logic [FIELD_BITS-1:0] r;
        reduced_sum_t          s;
        den_full = 64'(op.b) * 64'(op.d);
        cross_ad = 64'(op.a) * 64'(op.d);
        cross_bc = 64'(op.b) * 64'(op.c);
        num_full = {1'b0, cross_ad[31:0]} + {1'b0, cross_bc[31:0]};
        s.num = num_full[31:0];
        s.den = den_full[31:0];
        s.ovf = (|den_full[63:32]) | (|cross_ad[63:32]) | (|cross_bc[63:32]) | num_full[32];
        if (s.num != 0 && s.den != 0)
        begin
            x = s.num;
            y = s.den;
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            s.num = s.num / x;
            s.den = s.den / x;
        end
        return s;
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_word(input int unsigned mode);
        case (mode)
            0, 1:    return $urandom;
            2:       return $urandom_range(1, 1000);
            3:       return 32'(1) << $urandom_range(0, 31);
            4:       return $urandom_range(0, 65535);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return '1;
                    default: return 32'h8000_0000;
                endcase
            end
        endcase
    endfunction

    function automatic fractions_t random_fractions();
        fractions_t    op;
        int unsigned   mode;
        logic [31:0]   factor;
        mode = $urandom_range(0, 7);
        if (mode >= 6)
        begin
            // share a factor so the reduction has work to do
            factor = $urandom_range(2, 600);
            op.a = factor * $urandom_range(0, 3000);
            op.b = factor * $urandom_range(1, 3000);
            op.c = factor * $urandom_range(0, 3000);
            op.d = factor * $urandom_range(1, 3000);
        end
        else
        begin
            op.a = pick_word(mode);
            op.b = pick_word(mode);
            op.c = pick_word(mode);
            op.d = pick_word(mode);
        end
        case ($urandom_range(0, 19))
            0:       op.a = '0;
            1:       op.b = '0;
            2:       op.c = '0;
            3:       op.d = '0;
            default: ;
        endcase
        return op;
    endfunction

    task automatic table_row(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d,
                             input logic known, input logic [31:0] num,
                             input logic [31:0] den, input logic ovf);
        table_row_t row;
        row.op    = '{a: a, b: b, c: c, d: d};
        row.known = known;
        row.res   = '{num: num, den: den, ovf: ovf};
        directed_rows.push_back(row);
    endtask

    task automatic send_fractions(input fractions_t op, input reduced_sum_t expected);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            operands.valid <= 1'b0;
            @(posedge clk);
        end
        operands.valid              <= 1'b1;
        operands.first_numerator    <= op.a;
        operands.first_denominator  <= op.b;
        operands.second_numerator   <= op.c;
        operands.second_denominator <= op.d;
        do
            @(posedge clk);
        while (!operands.ready);
        pending_sums.push_back(expected);
    endtask

    always @(posedge clk)
    begin
        reduced_sum_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h/%h ovf %b",
                         $time, result.sum_numerator, result.sum_denominator,
                         result.overflow);
                mismatches++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (result.sum_numerator !== want.num)
                begin
                    $display("%0t sum_numerator: expected %h, actual %h",
                             $time, want.num, result.sum_numerator);
                    mismatches++;
                end
                if (result.sum_denominator !== want.den)
                begin
                    $display("%0t sum_denominator: expected %h, actual %h",
                             $time, want.den, result.sum_denominator);
                    mismatches++;
                end
                if (result.overflow !== want.ovf)
                begin
                    $display("%0t overflow: expected %b, actual %b",
                             $time, want.ovf, result.overflow);
                    mismatches++;
                end
            end
        end
        result.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    initial
    begin
        fractions_t op;
        operands.valid              = 1'b0;
        operands.first_numerator    = '0;
        operands.first_denominator  = '0;
        operands.second_numerator   = '0;
        operands.second_denominator = '0;

        table_row(32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0);
        table_row(32'd1, 32'd1, 32'd1, 32'd1, 1'b1, 32'd2, 32'd1, 1'b0);
        table_row('1, '1, '1, '1, 1'b1, 32'd2, 32'd1, 1'b1);
        table_row(32'd0, 32'd5, 32'd0, 32'd7, 1'b1, 32'd0, 32'd35, 1'b0);
        table_row(32'd3, 32'd0, 32'd4, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0);
        table_row(32'd3, 32'd0, 32'd4, 32'd5, 1'b1, 32'd15, 32'd0, 1'b0);
        table_row(32'd1, 32'd2, 32'd1, 32'd2, 1'b1, 32'd1, 32'd1, 1'b0);
        table_row(32'd1, 32'd2, 32'd1, 32'd3, 1'b1, 32'd5, 32'd6, 1'b0);
        table_row(32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1, 1'b1, 32'd0, 32'd1, 1'b1);
        table_row('1, 32'd1, 32'd0, 32'd1, 1'b1, '1, 32'd1, 1'b0);
        table_row('1, 32'd1, 32'd1, 32'd1, 1'b1, 32'd0, 32'd1, 1'b1);
        table_row(32'd1, '1, 32'd1, '1, 1'b1, 32'hFFFF_FFFE, 32'd1, 1'b1);
        table_row(32'd6, 32'd4, 32'd10, 32'd8, 1'b0, '0, '0, 1'b0);
        table_row(32'd12345, 32'd678, 32'd9, 32'd10, 1'b0, '0, '0, 1'b0);
        table_row(32'd3, 32'h1_0000, 32'd5, 32'h1_0000, 1'b0, '0, '0, 1'b0);
        table_row(32'd7, 32'h8000_0000, 32'd1, 32'd2, 1'b0, '0, '0, 1'b0);
        table_row(32'hDEAD_BEEF, 32'h1234_5678, 32'hCAFE_BABE, 32'h8765_4321,
                  1'b0, '0, '0, 1'b0);
        table_row(32'd0, '1, '1, 32'd0, 1'b0, '0, '0, 1'b0);
        table_row(32'd100, 32'd300, 32'd200, 32'd600, 1'b0, '0, '0, 1'b0);
        table_row(32'd17, 32'd51, 32'd34, 32'd85, 1'b0, '0, '0, 1'b0);
        table_row(32'h5555_5555, 32'd3, 32'hAAAA_AAAA, 32'd6, 1'b0, '0, '0, 1'b0);
        table_row(32'd1, 32'd1, 32'd0, 32'd0, 1'b0, '0, '0, 1'b0);
        table_row(32'd48, 32'd36, 32'd60, 32'd90, 1'b0, '0, '0, 1'b0);
        table_row(32'h0001_0000, 32'h0000_8000, 32'h0000_0002, 32'h0002_0000,
                  1'b0, '0, '0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_fractions(directed_rows[i].op,
                           directed_rows[i].known ? directed_rows[i].res
                                                  : predict_sum(directed_rows[i].op));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 300)
                steady <= 1'b1;
            else if (n == 550)
                steady <= 1'b0;
            op = random_fractions();
            send_fractions(op, predict_sum(op));
        end
        operands.valid <= 1'b0;

        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
